[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[hw/rtl/glzw_pkg.sv]
`timescale 1ns / 1ps

package glzw_pkg;

	localparam int MAX_CODE_BITS_DEF = 12;
	localparam int HASH_SIZE_DEF     = 5003;
	localparam int BLOCK_LIMIT_DEF   = 254;
	localparam int CODE_W            = 12;
	localparam logic [3:0] START_WIDTH_RST = 4'd9;
	localparam logic [3:0] WIDTH_MIN = 4'd3;
	localparam logic [3:0] WIDTH_MAX = 4'd9;

	typedef enum logic [1:0] {
		PK_PUT = 2'd0,
		PK_PAD = 2'd1,
		PK_END = 2'd2
	} pk_kind_t;

	typedef struct packed {
		logic              valid;
		pk_kind_t          kind;
		logic [CODE_W-1:0] code;
		logic [3:0]        width;
		logic              final_img;
	} pk_cmd_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] prefix;
		logic [7:0]        suffix;
	} dict_entry_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] block_position;
		logic       block_close;
		logic       image_done;
		logic       run_last;
	} byte_item_t;

	function automatic logic [3:0] clamp_width(input logic [3:0] w, input int cb);
		logic [3:0] r;
		r = w;
		if (r < WIDTH_MIN) r = WIDTH_MIN;
		if (r > WIDTH_MAX) r = WIDTH_MAX;
		if (r > 4'(cb - 1)) r = 4'(cb - 1);
		return r;
	endfunction

endpackage

[hw/rtl/glzw_ifs.sv]
`timescale 1ns / 1ps

interface glzw_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       last_pixel;
	modport source (output valid, output pixel, output last_pixel, input ready);
	modport sink (input valid, input pixel, input last_pixel, output ready);
endinterface

interface glzw_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [7:0] block_position;
	logic       block_close;
	logic       image_done;
	logic       run_last;
	modport source (output valid, output out_byte, output block_position, output block_close,
		output image_done, output run_last, input ready);
	modport sink (input valid, input out_byte, input block_position, input block_close,
		input image_done, input run_last, output ready);
endinterface

[hw/rtl/glzw_dict.sv]
`timescale 1ns / 1ps

module glzw_dict import glzw_pkg::*; #(
	parameter int HASH_SIZE = HASH_SIZE_DEF,
	localparam int HB = $clog2(HASH_SIZE)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [HB-1:0] rd_addr,
	output dict_entry_t   rd_data,
	input  logic          wr_en,
	input  logic [HB-1:0] wr_addr,
	input  dict_entry_t   wr_data
);

	dict_entry_t mem [HASH_SIZE];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/glzw_packer.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glzw_packer import glzw_pkg::*; #(
	parameter int BLOCK_LIMIT = BLOCK_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pk_cmd_t            cmd,
	output logic               cmd_ready,
	glzw_byte_if.source        byte_ch
);

	logic [19:0] accum_q;
	logic [4:0]  fill_q;
	logic [7:0]  bf_q;
	logic        held_v_q;
	byte_item_t  held_q;
	logic        out_v_q;
	byte_item_t  out_q;

	logic        out_free;
	logic        emit;
	logic        end_go;
	logic        put_go;
	logic        pad_go;
	logic        move;
	logic [7:0]  bf_inc;
	byte_item_t  new_byte;
	byte_item_t  held_fin;

	assign out_free = !out_v_q || byte_ch.ready;
	assign emit     = (fill_q >= 5'd8) && (!held_v_q || out_free);
	assign cmd_ready = (fill_q < 5'd8) && (cmd.kind != PK_END || !held_v_q || out_free);
	assign end_go   = cmd.valid && cmd_ready && cmd.kind == PK_END;
	assign put_go   = cmd.valid && cmd_ready && cmd.kind == PK_PUT;
	assign pad_go   = cmd.valid && cmd_ready && cmd.kind == PK_PAD;
	assign move     = held_v_q && (emit || end_go);
	assign bf_inc   = bf_q + 8'd1;

	always_comb begin
		new_byte.out_byte       = accum_q[7:0];
		new_byte.block_position = bf_inc;
		new_byte.block_close    = bf_inc >= 8'(BLOCK_LIMIT);
		new_byte.image_done     = 1'b0;
		new_byte.run_last       = 1'b0;
		held_fin = held_q;
		if (end_go) begin
			held_fin.run_last = 1'b1;
			if (cmd.final_img) begin
				held_fin.block_close = 1'b1;
				held_fin.image_done  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q  <= '0;
			fill_q   <= '0;
			bf_q     <= '0;
			held_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit) begin
				accum_q  <= accum_q >> 8;
				fill_q   <= fill_q - 5'd8;
				held_v_q <= 1'b1;
				bf_q     <= new_byte.block_close ? 8'd0 : bf_inc;
			end else if (put_go) begin
				accum_q <= accum_q | (20'(cmd.code) << fill_q);
				fill_q  <= fill_q + 5'(cmd.width);
			end else if (pad_go) begin
				if (fill_q != 5'd0) fill_q <= 5'd8;
			end else if (end_go) begin
				held_v_q <= 1'b0;
				if (cmd.final_img) begin
					bf_q    <= '0;
					accum_q <= '0;
					fill_q  <= '0;
				end
			end
			if (move) begin
				out_v_q <= 1'b1;
			end else if (byte_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) held_q <= new_byte;
		if (move) out_q <= held_fin;
	end

	assign byte_ch.valid          = out_v_q;
	assign byte_ch.out_byte       = out_q.out_byte;
	assign byte_ch.block_position = out_q.block_position;
	assign byte_ch.block_close    = out_q.block_close;
	assign byte_ch.image_done     = out_q.image_done;
	assign byte_ch.run_last       = out_q.run_last;

	`ASSERT_ALWAYS(a_fill_range, fill_q < 5'd20, "bit fill out of range")
	`ASSERT_ALWAYS(a_block_range, bf_q < 8'(BLOCK_LIMIT), "block fill past limit")
	`ASSERT_NEXT(a_end_flush, end_go, !held_v_q, "held byte not flushed at end")

endmodule

[hw/rtl/gif_lzw_hash_encoder.sv]
`timescale 1ns / 1ps

// Takes one palette pixel per request and emits the packed GIF LZW byte stream, one byte per
// output transfer, with sub-block position and close flags. One pixel is taken at a time: a
// dictionary hit goes through accept, hash read, compare and finish, each extra probe of the
// dictionary memory adds another read, and the packer holds off commands while it emits
// each code byte. Each image start and each table-full reset sweeps all HASH_SIZE dictionary
// entries (5003 by default) before the pixel completes.

module gif_lzw_hash_encoder import glzw_pkg::*; #(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
	parameter int HASH_SIZE     = HASH_SIZE_DEF,
	parameter int BLOCK_LIMIT   = BLOCK_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	glzw_pix_if.sink    pix_ch,
	glzw_byte_if.source byte_ch
);

	localparam int CB = MAX_CODE_BITS;
	localparam int HB = $clog2(HASH_SIZE);
	localparam logic [CB:0] TL = (CB+1)'(1) << CB;
	localparam logic [HB:0] HS = (HB+1)'(HASH_SIZE);

	typedef enum logic [11:0] {
		S_IDLE      = 12'b000000000001,
		S_SWEEP     = 12'b000000000010,
		S_START_PUT = 12'b000000000100,
		S_LOOKUP    = 12'b000000001000,
		S_CHECK     = 12'b000000010000,
		S_MISS_PUT  = 12'b000000100000,
		S_INSERT    = 12'b000001000000,
		S_FULL_PUT  = 12'b000010000000,
		S_FIN_PUT   = 12'b000100000000,
		S_FIN_EOI   = 12'b001000000000,
		S_FIN_PAD   = 12'b010000000000,
		S_END       = 12'b100000000000
	} state_t;

	state_t        state_q;
	logic [3:0]    start_q, lw_q, cw_q;
	logic [CB:0]   nf_q, wl_q;
	logic [CB-1:0] pend_q;
	logic [7:0]    pix_q;
	logic          last_q, started_q, full_q;
	logic [HB-1:0] k_q, disp_q, sw_q, steps_q;

	logic [3:0]    lw_cfg;
	logic [CB-1:0] clear_c, mask_c, eoi_c;
	logic [7:0]    pix_m;
	logic [HB:0]   hsum, k0w, ksub, kadd;
	logic [HB-1:0] k0, knext;
	logic          hit, match, exhausted;
	dict_entry_t   rd_data, wr_data;
	logic          rd_en, wr_en;
	logic [HB-1:0] rd_addr, wr_addr;
	pk_cmd_t       cmd;
	logic          cmd_ready, cmd_go;
	logic [3:0]    cw_inc;
	logic [CB:0]   wl_inc;

	assign lw_cfg  = clamp_width(start_q, CB);
	assign clear_c = CB'(1) << (lw_q - 4'd1);
	assign mask_c  = clear_c - CB'(1);
	assign eoi_c   = clear_c + CB'(1);
	assign pix_m   = pix_q & mask_c[7:0];

	assign hsum  = (HB+1)'({pix_m, {(CB-8){1'b0}}}) + (HB+1)'(pend_q);
	assign k0w   = (hsum >= HS) ? hsum - HS : hsum;
	assign k0    = k0w[HB-1:0];
	assign ksub  = {1'b0, k_q} - {1'b0, disp_q};
	assign kadd  = {1'b0, k_q} + (HS - {1'b0, disp_q});
	assign knext = (k_q >= disp_q) ? ksub[HB-1:0] : kadd[HB-1:0];

	assign hit       = rd_data.code != '0;
	assign match     = hit && rd_data.prefix == CODE_W'(pend_q) && rd_data.suffix == pix_m;
	assign exhausted = steps_q == HB'(HASH_SIZE - 1);

	assign rd_en   = (state_q == S_LOOKUP) || (state_q == S_CHECK && hit && !match && !exhausted);
	assign rd_addr = (state_q == S_LOOKUP) ? k0 : knext;
	assign wr_en   = (state_q == S_SWEEP) || (state_q == S_INSERT && nf_q < TL);
	assign wr_addr = (state_q == S_SWEEP) ? sw_q : k_q;

	always_comb begin
		wr_data = '0;
		if (state_q != S_SWEEP) begin
			wr_data.code   = CODE_W'(nf_q[CB-1:0]);
			wr_data.prefix = CODE_W'(pend_q);
			wr_data.suffix = pix_m;
		end
	end

	always_comb begin
		cmd.valid     = 1'b0;
		cmd.kind      = PK_PUT;
		cmd.code      = '0;
		cmd.width     = cw_q;
		cmd.final_img = last_q;
		unique case (state_q)
			S_START_PUT, S_FULL_PUT: begin
				cmd.valid = 1'b1;
				cmd.code  = CODE_W'(clear_c);
			end
			S_MISS_PUT, S_FIN_PUT: begin
				cmd.valid = 1'b1;
				cmd.code  = CODE_W'(pend_q);
			end
			S_FIN_EOI: begin
				cmd.valid = 1'b1;
				cmd.code  = CODE_W'(eoi_c);
			end
			S_FIN_PAD: begin
				cmd.valid = 1'b1;
				cmd.kind  = PK_PAD;
			end
			S_END: begin
				cmd.valid = 1'b1;
				cmd.kind  = PK_END;
			end
			default: begin
				cmd.valid = 1'b0;
			end
		endcase
	end

	assign cmd_go = cmd.valid && cmd_ready;
	assign cw_inc = cw_q + 4'd1;
	assign wl_inc = (cw_inc == 4'(CB)) ? TL : ((CB+1)'(1) << cw_inc) - (CB+1)'(1);

	assign pix_ch.ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			start_q   <= START_WIDTH_RST;
			lw_q      <= clamp_width(START_WIDTH_RST, CB);
			cw_q      <= clamp_width(START_WIDTH_RST, CB);
			nf_q      <= (CB+1)'((1 << (clamp_width(START_WIDTH_RST, CB) - 1)) + 2);
			wl_q      <= (CB+1)'((1 << clamp_width(START_WIDTH_RST, CB)) - 1);
			pend_q    <= '0;
			started_q <= 1'b0;
			full_q    <= 1'b0;
			sw_q      <= '0;
		end else begin
			if (cfg_we) start_q <= cfg_data;
			if (cmd_go && cmd.kind == PK_PUT && nf_q > wl_q) begin
				cw_q <= cw_inc;
				wl_q <= wl_inc;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pix_ch.valid) begin
						if (!started_q) begin
							lw_q    <= lw_cfg;
							cw_q    <= lw_cfg;
							wl_q    <= ((CB+1)'(1) << lw_cfg) - (CB+1)'(1);
							nf_q    <= ((CB+1)'(1) << (lw_cfg - 4'd1)) + (CB+1)'(2);
							full_q  <= 1'b0;
							sw_q    <= '0;
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_LOOKUP;
						end
					end
				end
				S_SWEEP: begin
					sw_q <= sw_q + HB'(1);
					if (sw_q == HB'(HASH_SIZE - 1)) begin
						state_q <= full_q ? S_FULL_PUT : S_START_PUT;
					end
				end
				S_START_PUT: begin
					if (cmd_go) begin
						pend_q    <= CB'(pix_m);
						started_q <= 1'b1;
						state_q   <= last_q ? S_FIN_PUT : S_END;
					end
				end
				S_LOOKUP: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (match) begin
						pend_q  <= rd_data.code[CB-1:0];
						state_q <= last_q ? S_FIN_PUT : S_END;
					end else if (!hit || exhausted) begin
						state_q <= S_MISS_PUT;
					end
				end
				S_MISS_PUT: begin
					if (cmd_go) state_q <= S_INSERT;
				end
				S_INSERT: begin
					pend_q <= CB'(pix_m);
					if (nf_q < TL) begin
						nf_q    <= nf_q + (CB+1)'(1);
						state_q <= last_q ? S_FIN_PUT : S_END;
					end else begin
						nf_q    <= (CB+1)'(clear_c) + (CB+1)'(2);
						full_q  <= 1'b1;
						sw_q    <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_FULL_PUT: begin
					if (cmd_go) begin
						cw_q    <= lw_q;
						wl_q    <= ((CB+1)'(1) << lw_q) - (CB+1)'(1);
						state_q <= last_q ? S_FIN_PUT : S_END;
					end
				end
				S_FIN_PUT: begin
					if (cmd_go) state_q <= S_FIN_EOI;
				end
				S_FIN_EOI: begin
					if (cmd_go) state_q <= S_FIN_PAD;
				end
				S_FIN_PAD: begin
					if (cmd_go) state_q <= S_END;
				end
				S_END: begin
					if (cmd_go) begin
						if (last_q) started_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pix_ch.valid) begin
			pix_q  <= pix_ch.pixel;
			last_q <= pix_ch.last_pixel;
		end
		if (state_q == S_LOOKUP) begin
			k_q     <= k0;
			disp_q  <= (k0 == '0) ? HB'(1) : HB'(HS - {1'b0, k0});
			steps_q <= '0;
		end else if (rd_en) begin
			k_q     <= knext;
			steps_q <= steps_q + HB'(1);
		end
	end

	glzw_dict #(
		.HASH_SIZE(HASH_SIZE)
	) u_dict (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	glzw_packer #(
		.BLOCK_LIMIT(BLOCK_LIMIT)
	) u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_ready(cmd_ready),
		.byte_ch  (byte_ch)
	);

endmodule

[test/gif_lzw_hash_encoder_tb.sv]
`timescale 1ns / 1ps

module gif_lzw_hash_encoder_tb;
	import glzw_pkg::*;

	localparam int HSIZE = 5003;
	localparam int BLK_MAX = 254;
	localparam int RUN_MAX = 9;

	typedef struct {
		logic [7:0] pixel;
		logic       last_pixel;
		int         n_typed;
		logic [7:0] typed[4];
	} pix_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_data = 4'd0;
	int errors = 0;
	int ready_mode = 0;

	glzw_pix_if pix_ch();
	glzw_byte_if byte_ch();

	gif_lzw_hash_encoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.pix_ch(pix_ch),
		.byte_ch(byte_ch)
	);

	always #10 clk = ~clk;

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// encoder state mirror
	logic [11:0] dict_code[HSIZE];
	logic [11:0] dict_prefix[HSIZE];
	logic [7:0]  dict_suffix[HSIZE];
	int unsigned prefix_code, avail_code, code_w, w_limit;
	int unsigned acc_bits, acc_fill, blk_fill, in_image, start_w, image_w;
	byte_item_t run_bytes[RUN_MAX];
	int run_cnt;
	byte_item_t byte_q[$];

	function automatic void emit_byte(int unsigned b);
		if (run_cnt >= RUN_MAX) return;
		blk_fill++;
		run_bytes[run_cnt] = '{out_byte: b[7:0], block_position: blk_fill[7:0],
			block_close: 1'b0, image_done: 1'b0, run_last: 1'b0};
		if (blk_fill >= BLK_MAX) begin
			run_bytes[run_cnt].block_close = 1'b1;
			blk_fill = 0;
		end
		run_cnt++;
	endfunction

	function automatic void pack_code(int unsigned c);
		acc_bits |= (c & 32'hfff) << acc_fill;
		acc_fill += code_w;
		while (acc_fill >= 8) begin
			emit_byte(acc_bits & 32'hff);
			acc_bits >>= 8;
			acc_fill -= 8;
		end
		acc_bits &= 32'hfffff;
		if (avail_code > w_limit) begin
			code_w++;
			w_limit = (code_w == 12) ? 4096 : (1 << code_w) - 1;
		end
	endfunction

	function automatic void wipe_dict();
		for (int i = 0; i < HSIZE; i++) dict_code[i] = '0;
	endfunction

	function automatic void encoder_reset();
		wipe_dict();
		for (int i = 0; i < HSIZE; i++) begin
			dict_prefix[i] = '0;
			dict_suffix[i] = '0;
		end
		start_w = 9;
		image_w = 9;
		prefix_code = 0;
		avail_code = 258;
		code_w = 9;
		w_limit = 511;
		acc_bits = 0;
		acc_fill = 0;
		blk_fill = 0;
		in_image = 0;
	endfunction

	function automatic void lzw_step(logic [7:0] px, logic lst);
		int unsigned clr, p, k, disp;
		bit hit;
		run_cnt = 0;
		hit = 0;
		if (!in_image) begin
			image_w = start_w < 3 ? 3 : (start_w > 9 ? 9 : start_w);
			clr = 1 << (image_w - 1);
			wipe_dict();
			avail_code = clr + 2;
			code_w = image_w;
			w_limit = (1 << image_w) - 1;
			acc_bits = 0;
			acc_fill = 0;
			blk_fill = 0;
			pack_code(clr);
			prefix_code = px & (clr - 1);
			in_image = 1;
		end else begin
			clr = 1 << (image_w - 1);
			p = px & (clr - 1);
			k = ((p << 4) + prefix_code) % HSIZE;
			if (dict_code[k] != 0) begin
				if (dict_prefix[k] == prefix_code && dict_suffix[k] == p) begin
					hit = 1;
				end else begin
					disp = (k == 0) ? 1 : HSIZE - k;
					for (int n = 1; n < HSIZE; n++) begin
						k = (k >= disp) ? k - disp : k + HSIZE - disp;
						if (dict_code[k] == 0) break;
						if (dict_prefix[k] == prefix_code && dict_suffix[k] == p) begin
							hit = 1;
							break;
						end
					end
				end
			end
			if (hit) begin
				prefix_code = dict_code[k];
			end else begin
				pack_code(prefix_code);
				if (avail_code < 4096) begin
					dict_code[k] = avail_code[11:0];
					dict_prefix[k] = prefix_code[11:0];
					dict_suffix[k] = p[7:0];
					avail_code++;
				end else begin
					wipe_dict();
					avail_code = clr + 2;
					pack_code(clr);
					code_w = image_w;
					w_limit = (1 << image_w) - 1;
				end
				prefix_code = p;
			end
		end
		if (lst) begin
			pack_code(prefix_code);
			pack_code(clr + 1);
			if (acc_fill > 0) emit_byte(acc_bits & 32'hff);
			if (run_cnt > 0) begin
				run_bytes[run_cnt-1].block_close = 1'b1;
				run_bytes[run_cnt-1].image_done = 1'b1;
			end
			blk_fill = 0;
			acc_bits = 0;
			acc_fill = 0;
			in_image = 0;
		end
		if (run_cnt > 0) run_bytes[run_cnt-1].run_last = 1'b1;
	endfunction

	// the receiver's stall pattern changes at random intervals
	always @(negedge clk) begin
		if ($urandom_range(63) == 0) ready_mode <= $urandom_range(2);
		case (ready_mode)
			0: byte_ch.ready <= 1'b1;
			1: byte_ch.ready <= $urandom_range(1);
			default: byte_ch.ready <= ($urandom_range(4) == 0);
		endcase
	end

	always @(posedge clk) begin
		byte_item_t want;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			if (byte_q.size() == 0) begin
				$error("unexpected byte %h", byte_ch.out_byte);
				errors++;
			end else begin
				want = byte_q.pop_front();
				if (byte_ch.out_byte !== want.out_byte) begin
					$error("out_byte exp %h got %h", want.out_byte, byte_ch.out_byte);
					errors++;
				end
				if (byte_ch.block_position !== want.block_position) begin
					$error("block_position exp %0d got %0d", want.block_position,
						byte_ch.block_position);
					errors++;
				end
				if (byte_ch.block_close !== want.block_close) begin
					$error("block_close exp %b got %b", want.block_close, byte_ch.block_close);
					errors++;
				end
				if (byte_ch.image_done !== want.image_done) begin
					$error("image_done exp %b got %b", want.image_done, byte_ch.image_done);
					errors++;
				end
				if (byte_ch.run_last !== want.run_last) begin
					$error("run_last exp %b got %b", want.run_last, byte_ch.run_last);
					errors++;
				end
			end
		end
	end

	int burst_left = 0;

	task automatic send_pixel(input pix_row_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(12, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
			if (gap > 0) begin
				pix_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= r.pixel;
		pix_ch.last_pixel <= r.last_pixel;
		do @(posedge clk); while (!pix_ch.ready);
		lzw_step(r.pixel, r.last_pixel);
		for (int i = 0; i < run_cnt; i++) begin
			if (r.n_typed > 0) begin
				run_bytes[i].out_byte = r.typed[i];
				run_bytes[i].block_position = 8'(i + 1);
			end
			byte_q.push_back(run_bytes[i]);
		end
		@(negedge clk);
	endtask

	task automatic drain_and_write(input logic [3:0] w);
		pix_ch.valid <= 1'b0;
		while (byte_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
		start_w = w;
	endtask

	task automatic send_image(input int len, input bit narrow);
		pix_row_t r;
		r.n_typed = 0;
		for (int i = 0; i < len; i++) begin
			r.pixel = (narrow && $urandom_range(3) != 0) ? 8'($urandom_range(3))
				: 8'($urandom_range(255));
			r.last_pixel = (i == len - 1);
			send_pixel(r);
		end
	endtask

	pix_row_t dir_rows[14];
	logic [3:0] widths[6];

	initial begin
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		pix_ch.last_pixel = 1'b0;
		byte_ch.ready = 1'b0;
		encoder_reset();
		// single-pixel image right after reset: clear, pixel 0, end code at 9 bits
		dir_rows[0] = '{8'd0, 1'b1, 4, '{8'h00, 8'h01, 8'h04, 8'h04}};
		dir_rows[1] = '{8'd255, 1'b0, 0, '{default: 0}};
		dir_rows[2] = '{8'd255, 1'b0, 0, '{default: 0}};
		dir_rows[3] = '{8'd255, 1'b0, 0, '{default: 0}};
		dir_rows[4] = '{8'd255, 1'b0, 0, '{default: 0}};
		dir_rows[5] = '{8'd0, 1'b0, 0, '{default: 0}};
		dir_rows[6] = '{8'd0, 1'b0, 0, '{default: 0}};
		dir_rows[7] = '{8'd0, 1'b0, 0, '{default: 0}};
		dir_rows[8] = '{8'd128, 1'b0, 0, '{default: 0}};
		dir_rows[9] = '{8'd1, 1'b0, 0, '{default: 0}};
		dir_rows[10] = '{8'd1, 1'b0, 0, '{default: 0}};
		dir_rows[11] = '{8'd1, 1'b0, 0, '{default: 0}};
		dir_rows[12] = '{8'd170, 1'b0, 0, '{default: 0}};
		dir_rows[13] = '{8'd85, 1'b1, 0, '{default: 0}};
		widths = '{4'd3, 4'd0, 4'd15, 4'd5, 4'd9, 4'($urandom_range(15))};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir_rows[i]) send_pixel(dir_rows[i]);
		foreach (widths[i]) begin
			drain_and_write(widths[i]);
			send_image(1, 0);
			send_image($urandom_range(4, 2), 1);
			send_image($urandom_range(3, 2), 0);
		end
		// long image to cross a sub-block boundary
		drain_and_write(4'd9);
		send_image(230, 0);
		pix_ch.valid <= 1'b0;
		while (byte_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
